@@ design/sticky_best_fit_layout_core_macros.svh @@
// Assertion macros shared by the layout core checks
`ifndef STICKY_BEST_FIT_LAYOUT_CORE_MACROS_SVH
`define STICKY_BEST_FIT_LAYOUT_CORE_MACROS_SVH

// same-cycle implication, reset masks the check
`define SBFL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masks the check
`define SBFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/sbfl_pkg.sv @@
// Shared constants, codes and types of the sticky best-fit layout core
package sbfl_pkg;

    localparam int MAX_SLICES_DEF   = 256;
    localparam int MAX_PREVIOUS_DEF = 256;
    localparam int OFFSET_BITS_DEF  = 40;

    localparam int ID_W     = 64;
    localparam int ARCH_W   = 16;
    localparam int HDR_W    = 16;
    localparam int PCT_W    = 7;
    localparam int KEPT_W   = 9;
    localparam int PCT_FULL = 100;

    localparam logic [15:0] HEADER_RST = 16'd64;
    localparam logic [6:0]  PCT_RST    = 7'd25;

    localparam logic [1:0] OP_LOAD_PREV  = 2'd0;
    localparam logic [1:0] OP_LOAD_SLICE = 2'd1;
    localparam logic [1:0] OP_RUN        = 2'd2;
    localparam logic [1:0] OP_QUERY      = 2'd3;

    localparam logic [0:0] CFG_HEADER = 1'b0;
    localparam logic [0:0] CFG_PCT    = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERLAP = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] KIND_FRESH   = 2'd0;
    localparam logic [1:0] KIND_OVER    = 2'd1;
    localparam logic [1:0] KIND_COMPACT = 2'd2;

    typedef struct packed {
        logic [1:0]        code;
        logic [1:0]        kind;
        logic [KEPT_W-1:0] kept_total;
    } t_run_res;

endpackage

@@ design/sticky_best_fit_layout_core.sv @@
// Top level of the sticky best-fit slice layout core
// Load items (previous entries and slices) are taken one per cycle while the core
// is idle and written straight into the entry memories; a query item reads the
// result memory into its read register and then loads the output register, and
// holds the input side until then, longer while the output register is still
// full. A run item holds the input side until the layout is done and its result
// is in the output register; each table walk reads one entry at a time through
// the single read port of the slice, offset and gap memories. The memories need
// no clearing pass after reset.
module sticky_best_fit_layout_core
    import sbfl_pkg::*;
#(
    parameter int MAX_SLICES   = MAX_SLICES_DEF,
    parameter int MAX_PREVIOUS = MAX_PREVIOUS_DEF,
    parameter int OFFSET_BITS  = OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_operation,
    input  logic [ID_W-1:0]        i_id_high,
    input  logic [ID_W-1:0]        i_id_low,
    input  logic [ARCH_W-1:0]      i_archive_number,
    input  logic [OFFSET_BITS-1:0] i_stored_bytes,
    input  logic [OFFSET_BITS-1:0] i_old_offset,
    input  logic [7:0]             i_query_index,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OFFSET_BITS-1:0] o_placed_offset,
    output logic                   o_was_kept,
    output logic [1:0]             o_layout_kind,
    output logic [KEPT_W-1:0]      o_kept_total,
    output logic [OFFSET_BITS-1:0] o_region_end,
    output logic [1:0]             o_status,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [0:0]             i_cfg_index,
    input  logic [HDR_W-1:0]       i_cfg_data
);

    localparam int OW  = OFFSET_BITS;
    localparam int SCW = $clog2(MAX_SLICES + 1);
    localparam int PCW = $clog2(MAX_PREVIOUS + 1);
    localparam int SAW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
    localparam int PAW = (MAX_PREVIOUS > 1) ? $clog2(MAX_PREVIOUS) : 1;
    localparam int QW  = (SCW > 8) ? SCW : 8;
    localparam int PW  = 2 * ID_W + ARCH_W + 2 * OW;
    localparam int SW  = 2 * ID_W + ARCH_W + OW;
    localparam int RW  = OW + 1;
    localparam int GW  = 2 * OW;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_QRD  = 2'd1;
    localparam logic [1:0] T_RUN  = 2'd2;
    localparam logic [1:0] T_SEND = 2'd3;

    logic [1:0]        r_state;
    logic [HDR_W-1:0]  r_header;
    logic [PCT_W-1:0]  r_pct;
    logic [PCW-1:0]    r_prev_count;
    logic [SCW-1:0]    r_slice_count;
    logic [1:0]        r_kind, r_status;
    logic [KEPT_W-1:0] r_kept;
    logic [OW-1:0]     r_rend;
    logic              r_sticky, r_q_ok;
    logic              r_out_valid;
    logic [OW-1:0]     r_o_off, r_o_end;
    logic              r_o_kept;
    logic [1:0]        r_o_kind, r_o_status;
    logic [KEPT_W-1:0] r_o_kept_total;

    logic           w_acc, w_free, w_run, w_prev_ok, w_slc_ok, w_q_issue, w_out_load;
    logic [QW-1:0]  w_q_ext;

    logic           e_prev_re, e_slc_re, e_res_re, e_res_we, e_gap_re, e_gap_we, e_done;
    logic [PAW-1:0] e_prev_raddr;
    logic [SAW-1:0] e_slc_raddr, e_res_raddr, e_res_waddr;
    logic [SCW-1:0] e_gap_raddr, e_gap_waddr;
    logic [RW-1:0]  e_res_wdata;
    logic [GW-1:0]  e_gap_wdata;
    t_run_res       e_res;
    logic [OW-1:0]  e_region_end;

    logic [PW-1:0]  w_prev_rdata;
    logic [SW-1:0]  w_slc_rdata;
    logic [RW-1:0]  w_res_rdata;
    logic [GW-1:0]  w_gap_rdata;
    logic           w_res_re, w_res_we;
    logic [SAW-1:0] w_res_raddr, w_res_waddr;
    logic [RW-1:0]  w_res_wdata;

    assign o_in_ready  = (r_state == T_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_free      = !r_out_valid || i_out_ready;
    assign w_run       = (r_state == T_RUN);
    assign w_out_load  = ((r_state == T_QRD) || (r_state == T_SEND)) && w_free;
    assign w_prev_ok   = w_acc && (i_operation == OP_LOAD_PREV) &&
                         (r_prev_count < PCW'(MAX_PREVIOUS));
    assign w_slc_ok    = w_acc && (i_operation == OP_LOAD_SLICE) &&
                         (r_slice_count < SCW'(MAX_SLICES));
    assign w_q_issue   = w_acc && (i_operation == OP_QUERY);
    assign w_q_ext     = QW'(i_query_index);

    assign w_res_re    = w_run ? e_res_re : w_q_issue;
    assign w_res_raddr = w_run ? e_res_raddr : w_q_ext[SAW-1:0];
    assign w_res_we    = w_run ? e_res_we : w_slc_ok;
    assign w_res_waddr = w_run ? e_res_waddr : r_slice_count[SAW-1:0];
    assign w_res_wdata = w_run ? e_res_wdata : '0;

    sbfl_ram #(.WIDTH(PW), .DEPTH(MAX_PREVIOUS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_prev_ok),
        .i_waddr (r_prev_count[PAW-1:0]),
        .i_wdata ({i_id_high, i_id_low, i_archive_number, i_old_offset, i_stored_bytes}),
        .i_re    (e_prev_re),
        .i_raddr (e_prev_raddr),
        .o_rdata (w_prev_rdata)
    );

    sbfl_ram #(.WIDTH(SW), .DEPTH(MAX_SLICES)) u_slc_ram (
        .i_clk   (i_clk),
        .i_we    (w_slc_ok),
        .i_waddr (r_slice_count[SAW-1:0]),
        .i_wdata ({i_id_high, i_id_low, i_archive_number, i_stored_bytes}),
        .i_re    (e_slc_re),
        .i_raddr (e_slc_raddr),
        .o_rdata (w_slc_rdata)
    );

    sbfl_ram #(.WIDTH(RW), .DEPTH(MAX_SLICES)) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (w_res_we),
        .i_waddr (w_res_waddr),
        .i_wdata (w_res_wdata),
        .i_re    (w_res_re),
        .i_raddr (w_res_raddr),
        .o_rdata (w_res_rdata)
    );

    sbfl_ram #(.WIDTH(GW), .DEPTH(MAX_SLICES + 1)) u_gap_ram (
        .i_clk   (i_clk),
        .i_we    (e_gap_we),
        .i_waddr (e_gap_waddr),
        .i_wdata (e_gap_wdata),
        .i_re    (e_gap_re),
        .i_raddr (e_gap_raddr),
        .o_rdata (w_gap_rdata)
    );

    sbfl_engine #(
        .MAX_SLICES   (MAX_SLICES),
        .MAX_PREVIOUS (MAX_PREVIOUS),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_acc && (i_operation == OP_RUN)),
        .i_header      (r_header),
        .i_pct         (r_pct),
        .i_prev_count  (r_prev_count),
        .i_slice_count (r_slice_count),
        .o_prev_re     (e_prev_re),
        .o_prev_raddr  (e_prev_raddr),
        .i_prev_rdata  (w_prev_rdata),
        .o_slc_re      (e_slc_re),
        .o_slc_raddr   (e_slc_raddr),
        .i_slc_rdata   (w_slc_rdata),
        .o_res_re      (e_res_re),
        .o_res_raddr   (e_res_raddr),
        .i_res_rdata   (w_res_rdata),
        .o_res_we      (e_res_we),
        .o_res_waddr   (e_res_waddr),
        .o_res_wdata   (e_res_wdata),
        .o_gap_re      (e_gap_re),
        .o_gap_raddr   (e_gap_raddr),
        .i_gap_rdata   (w_gap_rdata),
        .o_gap_we      (e_gap_we),
        .o_gap_waddr   (e_gap_waddr),
        .o_gap_wdata   (e_gap_wdata),
        .o_done        (e_done),
        .o_res         (e_res),
        .o_region_end  (e_region_end)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= T_IDLE;
            r_header      <= HEADER_RST;
            r_pct         <= PCT_RST;
            r_prev_count  <= '0;
            r_slice_count <= '0;
            r_kind        <= KIND_FRESH;
            r_kept        <= '0;
            r_rend        <= '0;
            r_status      <= ST_OK;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_HEADER: r_header <= i_cfg_data;
                    CFG_PCT:    r_pct    <= i_cfg_data[PCT_W-1:0];
                    default:    r_pct    <= r_pct;
                endcase
            end
            if (r_out_valid && i_out_ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (w_acc) begin
                        unique case (i_operation)
                            OP_LOAD_PREV: begin
                                if (w_prev_ok) begin
                                    r_prev_count <= r_prev_count + 1'b1;
                                end else begin
                                    r_status <= ST_FULL;
                                end
                            end
                            OP_LOAD_SLICE: begin
                                if (w_slc_ok) begin
                                    r_slice_count <= r_slice_count + 1'b1;
                                end else begin
                                    r_status <= ST_FULL;
                                end
                            end
                            OP_RUN: begin
                                r_sticky <= (r_status == ST_FULL);
                                r_state  <= T_RUN;
                            end
                            OP_QUERY: begin
                                r_q_ok  <= (w_q_ext < QW'(r_slice_count));
                                r_state <= T_QRD;
                            end
                            default: r_state <= T_IDLE;
                        endcase
                    end
                end
                T_QRD: begin
                    if (w_free) begin
                        r_out_valid    <= 1'b1;
                        r_o_off        <= r_q_ok ? w_res_rdata[OW:1] : '0;
                        r_o_kept       <= r_q_ok && w_res_rdata[0];
                        r_o_kind       <= r_kind;
                        r_o_kept_total <= r_kept;
                        r_o_end        <= r_rend;
                        r_o_status     <= r_status;
                        r_state        <= T_IDLE;
                    end
                end
                T_RUN: begin
                    if (e_done) begin
                        r_kind   <= e_res.kind;
                        r_kept   <= e_res.kept_total;
                        r_rend   <= e_region_end;
                        r_status <= r_sticky ? ST_FULL : e_res.code;
                        r_state  <= T_SEND;
                    end
                end
                T_SEND: begin
                    if (w_free) begin
                        r_out_valid    <= 1'b1;
                        r_o_off        <= '0;
                        r_o_kept       <= 1'b0;
                        r_o_kind       <= r_kind;
                        r_o_kept_total <= r_kept;
                        r_o_end        <= r_rend;
                        r_o_status     <= r_status;
                        r_state        <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_placed_offset = r_o_off;
    assign o_was_kept      = r_o_kept;
    assign o_layout_kind   = r_o_kind;
    assign o_kept_total    = r_o_kept_total;
    assign o_region_end    = r_o_end;
    assign o_status        = r_o_status;

endmodule

@@ design/sbfl_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module sbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/sbfl_engine.sv @@
// Layout run sequencer: match, gap build, best-fit placement, compaction
module sbfl_engine
    import sbfl_pkg::*;
#(
    parameter int MAX_SLICES   = MAX_SLICES_DEF,
    parameter int MAX_PREVIOUS = MAX_PREVIOUS_DEF,
    parameter int OFFSET_BITS  = OFFSET_BITS_DEF,
    localparam int OW  = OFFSET_BITS,
    localparam int SCW = $clog2(MAX_SLICES + 1),
    localparam int PCW = $clog2(MAX_PREVIOUS + 1),
    localparam int SAW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1,
    localparam int PAW = (MAX_PREVIOUS > 1) ? $clog2(MAX_PREVIOUS) : 1,
    localparam int PW  = 2 * ID_W + ARCH_W + 2 * OW,
    localparam int SW  = 2 * ID_W + ARCH_W + OW,
    localparam int RW  = OW + 1,
    localparam int GW  = 2 * OW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [HDR_W-1:0] i_header,
    input  logic [PCT_W-1:0] i_pct,
    input  logic [PCW-1:0]   i_prev_count,
    input  logic [SCW-1:0]   i_slice_count,
    output logic             o_prev_re,
    output logic [PAW-1:0]   o_prev_raddr,
    input  logic [PW-1:0]    i_prev_rdata,
    output logic             o_slc_re,
    output logic [SAW-1:0]   o_slc_raddr,
    input  logic [SW-1:0]    i_slc_rdata,
    output logic             o_res_re,
    output logic [SAW-1:0]   o_res_raddr,
    input  logic [RW-1:0]    i_res_rdata,
    output logic             o_res_we,
    output logic [SAW-1:0]   o_res_waddr,
    output logic [RW-1:0]    o_res_wdata,
    output logic             o_gap_re,
    output logic [SCW-1:0]   o_gap_raddr,
    input  logic [GW-1:0]    i_gap_rdata,
    output logic             o_gap_we,
    output logic [SCW-1:0]   o_gap_waddr,
    output logic [GW-1:0]    o_gap_wdata,
    output logic             o_done,
    output t_run_res         o_res,
    output logic [OW-1:0]    o_region_end
);

    localparam int KW = 2 * OW + SCW;
    localparam int MW = OW + PCT_W;

    localparam logic [4:0] E_IDLE  = 5'd0;
    localparam logic [4:0] E_FRD   = 5'd1;
    localparam logic [4:0] E_FWR   = 5'd2;
    localparam logic [4:0] E_MSRD  = 5'd3;
    localparam logic [4:0] E_MPRD  = 5'd4;
    localparam logic [4:0] E_MPCMP = 5'd5;
    localparam logic [4:0] E_KRD   = 5'd6;
    localparam logic [4:0] E_KCMP  = 5'd7;
    localparam logic [4:0] E_KPICK = 5'd8;
    localparam logic [4:0] E_LRD   = 5'd9;
    localparam logic [4:0] E_LCMP  = 5'd10;
    localparam logic [4:0] E_LPICK = 5'd11;
    localparam logic [4:0] E_GRD   = 5'd12;
    localparam logic [4:0] E_GCMP  = 5'd13;
    localparam logic [4:0] E_GDONE = 5'd14;
    localparam logic [4:0] E_PMUL  = 5'd15;
    localparam logic [4:0] E_PCMP  = 5'd16;
    localparam logic [4:0] E_CLR   = 5'd17;
    localparam logic [4:0] E_DONE  = 5'd18;

    logic [4:0]     r_state, n_state;
    logic [SCW-1:0] r_i, n_i, r_g, n_g, r_ng, n_ng, r_nk, n_nk;
    logic [PCW-1:0] r_j, n_j;
    logic [OW-1:0]  r_end, n_end, r_gsum, n_gsum;
    logic [KW-1:0]  r_best, n_best, r_last, n_last;
    logic           r_found, n_found, r_have_last, n_have_last, r_gfound, n_gfound;
    logic [OW-1:0]  r_bsz, n_bsz, r_lsz, n_lsz, r_gsz, n_gsz, r_goff, n_goff;
    logic [SCW-1:0] r_bix, n_bix, r_lix, n_lix, r_gix, n_gix;
    logic [MW-1:0]  r_p1, n_p1, r_p2, n_p2;
    logic           r_compact, n_compact;
    logic [1:0]     r_code, n_code, r_kind, n_kind;

    logic [ID_W-1:0]   w_p_hi, w_p_lo, w_s_hi, w_s_lo;
    logic [ARCH_W-1:0] w_p_arch, w_s_arch;
    logic [OW-1:0]     w_p_off, w_p_size, w_s_size, w_r_off, w_g_off, w_g_size;
    logic [OW-1:0]     w_hdr, w_b_off, w_b_size;
    logic              w_r_kept;
    logic [KW-1:0]     w_key;
    logic [OW:0]       w_sum;
    logic              w_fail;
    logic [1:0]        w_fail_code;

    assign w_p_hi   = i_prev_rdata[PW-1 -: ID_W];
    assign w_p_lo   = i_prev_rdata[PW-ID_W-1 -: ID_W];
    assign w_p_arch = i_prev_rdata[2*OW+ARCH_W-1 -: ARCH_W];
    assign w_p_off  = i_prev_rdata[2*OW-1 -: OW];
    assign w_p_size = i_prev_rdata[OW-1:0];
    assign w_s_hi   = i_slc_rdata[SW-1 -: ID_W];
    assign w_s_lo   = i_slc_rdata[SW-ID_W-1 -: ID_W];
    assign w_s_arch = i_slc_rdata[OW+ARCH_W-1 -: ARCH_W];
    assign w_s_size = i_slc_rdata[OW-1:0];
    assign w_r_off  = i_res_rdata[OW:1];
    assign w_r_kept = i_res_rdata[0];
    assign w_g_off  = i_gap_rdata[2*OW-1 -: OW];
    assign w_g_size = i_gap_rdata[OW-1:0];
    assign w_hdr    = OW'(i_header);
    assign w_key    = {w_r_off, w_s_size, r_i};
    assign w_b_off  = r_best[KW-1 -: OW];
    assign w_b_size = r_best[KW-OW-1 -: OW];

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_g         = r_g;
        n_ng        = r_ng;
        n_nk        = r_nk;
        n_end       = r_end;
        n_gsum      = r_gsum;
        n_best      = r_best;
        n_last      = r_last;
        n_found     = r_found;
        n_have_last = r_have_last;
        n_gfound    = r_gfound;
        n_bsz       = r_bsz;
        n_bix       = r_bix;
        n_lsz       = r_lsz;
        n_lix       = r_lix;
        n_gsz       = r_gsz;
        n_gix       = r_gix;
        n_goff      = r_goff;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_compact   = r_compact;
        n_code      = r_code;
        n_kind      = r_kind;
        o_prev_re    = 1'b0;
        o_prev_raddr = r_j[PAW-1:0];
        o_slc_re     = 1'b0;
        o_slc_raddr  = r_i[SAW-1:0];
        o_res_re     = 1'b0;
        o_res_raddr  = r_i[SAW-1:0];
        o_res_we     = 1'b0;
        o_res_waddr  = r_i[SAW-1:0];
        o_res_wdata  = '0;
        o_gap_re     = 1'b0;
        o_gap_raddr  = r_g;
        o_gap_we     = 1'b0;
        o_gap_waddr  = r_ng;
        o_gap_wdata  = '0;
        w_sum        = '0;
        w_fail       = 1'b0;
        w_fail_code  = ST_OK;

        unique case (r_state)
            E_IDLE: begin
                if (i_start) begin
                    n_i         = '0;
                    n_j         = '0;
                    n_ng        = '0;
                    n_nk        = '0;
                    n_gsum      = '0;
                    n_end       = w_hdr;
                    n_found     = 1'b0;
                    n_have_last = 1'b0;
                    n_compact   = 1'b0;
                    n_state     = (i_prev_count == '0) ? E_FRD : E_MSRD;
                end
            end
            E_FRD: begin
                if (r_i == i_slice_count) begin
                    n_code  = ST_OK;
                    n_kind  = r_compact ? KIND_COMPACT : KIND_FRESH;
                    n_nk    = '0;
                    n_state = E_DONE;
                end else begin
                    o_slc_re = 1'b1;
                    n_state  = E_FWR;
                end
            end
            E_FWR: begin
                o_res_we    = 1'b1;
                o_res_wdata = {r_end, 1'b0};
                w_sum       = {1'b0, r_end} + {1'b0, w_s_size};
                if (w_sum[OW]) begin
                    w_fail      = 1'b1;
                    w_fail_code = ST_FULL;
                end else begin
                    n_end   = w_sum[OW-1:0];
                    n_i     = r_i + 1'b1;
                    n_state = E_FRD;
                end
            end
            E_MSRD: begin
                if (r_i == i_slice_count) begin
                    n_i     = '0;
                    n_state = E_KRD;
                end else begin
                    o_slc_re = 1'b1;
                    n_j      = '0;
                    n_state  = E_MPRD;
                end
            end
            E_MPRD: begin
                if (r_j == i_prev_count) begin
                    o_res_we    = 1'b1;
                    o_res_wdata = '0;
                    n_i         = r_i + 1'b1;
                    n_state     = E_MSRD;
                end else begin
                    o_prev_re = 1'b1;
                    n_state   = E_MPCMP;
                end
            end
            E_MPCMP: begin
                if (w_p_hi == w_s_hi && w_p_lo == w_s_lo) begin
                    o_res_we = 1'b1;
                    n_i      = r_i + 1'b1;
                    n_state  = E_MSRD;
                    if (w_p_arch == w_s_arch && w_s_size <= w_p_size) begin
                        o_res_wdata = {w_p_off, 1'b1};
                        n_nk        = r_nk + 1'b1;
                        w_sum       = {1'b0, w_p_off} + {1'b0, w_s_size};
                        if (w_sum[OW]) begin
                            w_fail      = 1'b1;
                            w_fail_code = ST_FULL;
                        end
                    end else begin
                        o_res_wdata = '0;
                    end
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = E_MPRD;
                end
            end
            E_KRD: begin
                if (r_i == i_slice_count) begin
                    n_state = E_KPICK;
                end else begin
                    o_slc_re = 1'b1;
                    o_res_re = 1'b1;
                    n_state  = E_KCMP;
                end
            end
            E_KCMP: begin
                if (w_r_kept && (!r_have_last || w_key > r_last) &&
                    (!r_found || w_key < r_best)) begin
                    n_best  = w_key;
                    n_found = 1'b1;
                end
                n_i     = r_i + 1'b1;
                n_state = E_KRD;
            end
            E_KPICK: begin
                n_i     = '0;
                n_found = 1'b0;
                if (!r_found) begin
                    n_have_last = 1'b0;
                    n_state     = E_LRD;
                end else if (w_b_off < r_end) begin
                    w_fail      = 1'b1;
                    w_fail_code = ST_OVERLAP;
                end else begin
                    if (w_b_off > r_end) begin
                        o_gap_we    = 1'b1;
                        o_gap_wdata = {r_end, w_b_off - r_end};
                        n_ng        = r_ng + 1'b1;
                        n_gsum      = r_gsum + (w_b_off - r_end);
                    end
                    n_end       = w_b_off + w_b_size;
                    n_last      = r_best;
                    n_have_last = 1'b1;
                    n_state     = E_KRD;
                end
            end
            E_LRD: begin
                if (r_i == i_slice_count) begin
                    n_state = E_LPICK;
                end else begin
                    o_slc_re = 1'b1;
                    o_res_re = 1'b1;
                    n_state  = E_LCMP;
                end
            end
            E_LCMP: begin
                if (!w_r_kept &&
                    (!r_have_last || w_s_size < r_lsz ||
                     (w_s_size == r_lsz && r_i > r_lix)) &&
                    (!r_found || w_s_size > r_bsz)) begin
                    n_bsz   = w_s_size;
                    n_bix   = r_i;
                    n_found = 1'b1;
                end
                n_i     = r_i + 1'b1;
                n_state = E_LRD;
            end
            E_LPICK: begin
                if (!r_found) begin
                    n_state = E_PMUL;
                end else begin
                    n_g      = '0;
                    n_gfound = 1'b0;
                    n_state  = E_GRD;
                end
            end
            E_GRD: begin
                if (r_g == r_ng) begin
                    n_state = E_GDONE;
                end else begin
                    o_gap_re = 1'b1;
                    n_state  = E_GCMP;
                end
            end
            E_GCMP: begin
                if (w_g_size >= r_bsz && (!r_gfound || w_g_size < r_gsz)) begin
                    n_gix    = r_g;
                    n_gsz    = w_g_size;
                    n_goff   = w_g_off;
                    n_gfound = 1'b1;
                end
                n_g     = r_g + 1'b1;
                n_state = E_GRD;
            end
            E_GDONE: begin
                o_res_we    = 1'b1;
                o_res_waddr = r_bix[SAW-1:0];
                n_lsz       = r_bsz;
                n_lix       = r_bix;
                n_have_last = 1'b1;
                n_found     = 1'b0;
                n_i         = '0;
                n_state     = E_LRD;
                if (r_gfound) begin
                    o_res_wdata = {r_goff, 1'b0};
                    o_gap_we    = 1'b1;
                    o_gap_waddr = r_gix;
                    o_gap_wdata = {r_goff + r_bsz, r_gsz - r_bsz};
                    n_gsum      = r_gsum - r_bsz;
                end else begin
                    o_res_wdata = {r_end, 1'b0};
                    w_sum       = {1'b0, r_end} + {1'b0, r_bsz};
                    if (w_sum[OW]) begin
                        w_fail      = 1'b1;
                        w_fail_code = ST_FULL;
                    end else begin
                        n_end = w_sum[OW-1:0];
                    end
                end
            end
            E_PMUL: begin
                n_p1    = MW'(r_gsum) * MW'(PCT_FULL);
                n_p2    = MW'(r_end - w_hdr) * MW'(i_pct);
                n_state = E_PCMP;
            end
            E_PCMP: begin
                if (r_p1 > r_p2) begin
                    n_compact = 1'b1;
                    n_end     = w_hdr;
                    n_i       = '0;
                    n_state   = E_FRD;
                end else begin
                    n_code  = ST_OK;
                    n_kind  = KIND_OVER;
                    n_state = E_DONE;
                end
            end
            E_CLR: begin
                if (r_i == i_slice_count) begin
                    n_state = E_DONE;
                end else begin
                    o_res_we    = 1'b1;
                    o_res_wdata = '0;
                    n_i         = r_i + 1'b1;
                end
            end
            E_DONE: begin
                n_state = E_IDLE;
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase

        if (w_fail) begin
            n_code  = w_fail_code;
            n_kind  = KIND_FRESH;
            n_nk    = '0;
            n_end   = '0;
            n_i     = '0;
            n_state = E_CLR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i         <= n_i;
        r_j         <= n_j;
        r_g         <= n_g;
        r_ng        <= n_ng;
        r_nk        <= n_nk;
        r_end       <= n_end;
        r_gsum      <= n_gsum;
        r_best      <= n_best;
        r_last      <= n_last;
        r_found     <= n_found;
        r_have_last <= n_have_last;
        r_gfound    <= n_gfound;
        r_bsz       <= n_bsz;
        r_bix       <= n_bix;
        r_lsz       <= n_lsz;
        r_lix       <= n_lix;
        r_gsz       <= n_gsz;
        r_gix       <= n_gix;
        r_goff      <= n_goff;
        r_p1        <= n_p1;
        r_p2        <= n_p2;
        r_compact   <= n_compact;
        r_code      <= n_code;
        r_kind      <= n_kind;
    end

    assign o_done           = (r_state == E_DONE);
    assign o_res.code       = r_code;
    assign o_res.kind       = r_kind;
    assign o_res.kept_total = (r_kind == KIND_OVER) ? KEPT_W'(r_nk) : '0;
    assign o_region_end     = r_end;

endmodule

@@ design/sbfl_checker.sv @@
// Port-level checks of the layout core and their bind to the top level
`include "sticky_best_fit_layout_core_macros.svh"

module sbfl_checker
    import sbfl_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic [1:0]             i_operation,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic                   o_was_kept,
    input logic [1:0]             o_layout_kind,
    input logic [KEPT_W-1:0]      o_kept_total,
    input logic [OFFSET_BITS-1:0] o_region_end,
    input logic [1:0]             o_status
);

    `SBFL_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "item dropped")

    `SBFL_ASSERT_NEXT(a_run_blocks, i_in_valid && o_in_ready && i_operation == OP_RUN, !o_in_ready, "run did not hold input")

    `SBFL_ASSERT_NOW(a_overlap_clear, o_out_valid && o_status == ST_OVERLAP, o_layout_kind == KIND_FRESH && o_kept_total == '0 && o_region_end == '0, "failed layout not cleared")

    `SBFL_ASSERT_NOW(a_kept_kind, o_out_valid && o_layout_kind != KIND_OVER, o_kept_total == '0, "kept count outside over-previous layout")

    `SBFL_ASSERT_NOW(a_flag_kind, o_out_valid && o_was_kept, o_layout_kind == KIND_OVER, "kept slice outside over-previous layout")

endmodule

bind sticky_best_fit_layout_core sbfl_checker #(.OFFSET_BITS(OFFSET_BITS)) u_sbfl_checker (.*);

@@ verif/tb_sticky_best_fit_layout_core.sv @@
// Self-checking testbench of the sticky best-fit layout core with a built-in layout predictor
module tb_sticky_best_fit_layout_core;
    import sbfl_pkg::*;

    localparam int          OBITS    = OFFSET_BITS_DEF;
    localparam logic [63:0] OMASK    = (64'd1 << OBITS) - 64'd1;
    localparam int          NSLICE   = MAX_SLICES_DEF;
    localparam int          NPREV    = MAX_PREVIOUS_DEF;
    localparam longint      LIMIT    = 3000000;
    localparam int          ROUNDS   = 25;
    localparam int          HOLD_LEN = 400;

    typedef struct {
        logic [1:0]       op;
        logic [63:0]      idh;
        logic [63:0]      idl;
        logic [15:0]      arch;
        logic [OBITS-1:0] size;
        logic [OBITS-1:0] off;
        logic [7:0]       q;
    } t_layout_item;

    typedef struct {
        logic [OBITS-1:0]  offset;
        logic              kept;
        logic [1:0]        kind;
        logic [KEPT_W-1:0] kept_total;
        logic [OBITS-1:0]  region_end;
        logic [1:0]        status;
    } t_layout_answer;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             operation;
    logic [ID_W-1:0]        id_high;
    logic [ID_W-1:0]        id_low;
    logic [ARCH_W-1:0]      archive_number;
    logic [OBITS-1:0]       stored_bytes;
    logic [OBITS-1:0]       old_offset;
    logic [7:0]             query_index;
    logic                   out_valid;
    logic                   out_ready;
    logic [OBITS-1:0]       placed_offset;
    logic                   was_kept;
    logic [1:0]             layout_kind;
    logic [KEPT_W-1:0]      kept_total;
    logic [OBITS-1:0]       region_end;
    logic [1:0]             status;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [0:0]             cfg_index;
    logic [HDR_W-1:0]       cfg_data;

    sticky_best_fit_layout_core DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_operation      (operation),
        .i_id_high        (id_high),
        .i_id_low         (id_low),
        .i_archive_number (archive_number),
        .i_stored_bytes   (stored_bytes),
        .i_old_offset     (old_offset),
        .i_query_index    (query_index),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_placed_offset  (placed_offset),
        .o_was_kept       (was_kept),
        .o_layout_kind    (layout_kind),
        .o_kept_total     (kept_total),
        .o_region_end     (region_end),
        .o_status         (status),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    t_layout_item   item_backlog[$];
    t_layout_answer expected_answers[$];
    int             mismatch_count = 0;
    longint         cycle_count = 0;
    bit             in_took = 0;
    int             hold_start = 0;
    int             hold_seen = 0;
    int             hold_left = 0;

    // predictor state
    logic [63:0]      hdr_r;
    logic [63:0]      pct_r;
    logic [63:0]      pv_idh [NPREV];
    logic [63:0]      pv_idl [NPREV];
    logic [15:0]      pv_arch [NPREV];
    logic [63:0]      pv_off [NPREV];
    logic [63:0]      pv_size [NPREV];
    logic [63:0]      sl_idh [NSLICE];
    logic [63:0]      sl_idl [NSLICE];
    logic [15:0]      sl_arch [NSLICE];
    logic [63:0]      sl_size [NSLICE];
    logic [63:0]      sl_off [NSLICE];
    logic             sl_kept [NSLICE];
    logic [63:0]      gap_o [NSLICE+1];
    logic [63:0]      gap_s [NSLICE+1];
    logic [63:0]      reg_end;
    int               prev_n;
    int               slice_n;
    logic [1:0]       kind_r;
    int               kept_r;
    logic [1:0]       stat_r;

    // stimulus generator state
    logic [63:0] gp_idh[$];
    logic [63:0] gp_idl[$];
    logic [15:0] gp_arch[$];
    logic [39:0] gp_size[$];
    bit          gp_used[$];
    logic [39:0] gen_cursor = 40'd2000;
    int          gen_slices = 0;
    int          gen_prevs = 0;

    initial clk = 0;
    always #5 clk = ~clk;

    function automatic bit place_fresh();
        logic [63:0] off;
        off = hdr_r;
        for (int i = 0; i < slice_n; i++) begin
            sl_off[i] = off;
            sl_kept[i] = 0;
            off = off + sl_size[i];
            if (off > OMASK) return 0;
        end
        reg_end = off;
        return 1;
    endfunction

    function automatic logic [1:0] place_slices();
        int          kept_ix[NSLICE];
        int          loose_ix[NSLICE];
        int          nk, nu, ng, v, p, u, e, best;
        bit          hit, found;
        logic [63:0] lim, gsum, sz;
        logic [127:0] lhs, rhs;
        nk = 0;
        nu = 0;
        ng = 0;
        gsum = 0;
        if (prev_n == 0) begin
            if (!place_fresh()) return ST_FULL;
            kind_r = KIND_FRESH;
            kept_r = 0;
            return ST_OK;
        end
        for (int i = 0; i < slice_n; i++) begin
            hit = 0;
            for (int j = 0; j < prev_n; j++) begin
                if (pv_idh[j] == sl_idh[i] && pv_idl[j] == sl_idl[i]) begin
                    hit = (pv_arch[j] == sl_arch[i]) && (sl_size[i] <= pv_size[j]);
                    if (hit) sl_off[i] = pv_off[j];
                    break;
                end
            end
            sl_kept[i] = hit;
            if (hit) begin
                if (sl_off[i] + sl_size[i] > OMASK) return ST_FULL;
                kept_ix[nk] = i;
                nk++;
            end else begin
                sl_off[i] = 0;
                loose_ix[nu] = i;
                nu++;
            end
        end
        for (int k = 1; k < nk; k++) begin
            v = kept_ix[k];
            p = k;
            while (p > 0) begin
                u = kept_ix[p-1];
                if (sl_off[u] < sl_off[v] || (sl_off[u] == sl_off[v] && sl_size[u] <= sl_size[v]))
                    break;
                kept_ix[p] = u;
                p--;
            end
            kept_ix[p] = v;
        end
        lim = hdr_r;
        for (int k = 0; k < nk; k++) begin
            e = kept_ix[k];
            if (sl_off[e] < lim) return ST_OVERLAP;
            if (sl_off[e] > lim) begin
                gap_o[ng] = lim;
                gap_s[ng] = sl_off[e] - lim;
                ng++;
            end
            lim = sl_off[e] + sl_size[e];
        end
        for (int k = 1; k < nu; k++) begin
            v = loose_ix[k];
            p = k;
            while (p > 0 && sl_size[loose_ix[p-1]] < sl_size[v]) begin
                loose_ix[p] = loose_ix[p-1];
                p--;
            end
            loose_ix[p] = v;
        end
        for (int k = 0; k < nu; k++) begin
            e = loose_ix[k];
            sz = sl_size[e];
            found = 0;
            best = 0;
            for (int g = 0; g < ng; g++) begin
                if (gap_s[g] >= sz && (!found || gap_s[g] < gap_s[best])) begin
                    best = g;
                    found = 1;
                end
            end
            if (found) begin
                sl_off[e] = gap_o[best];
                gap_o[best] = gap_o[best] + sz;
                gap_s[best] = gap_s[best] - sz;
            end else begin
                sl_off[e] = lim;
                lim = lim + sz;
                if (lim > OMASK) return ST_FULL;
            end
        end
        for (int k = 0; k < ng; k++) gsum = gsum + gap_s[k];
        lhs = 128'(gsum) * 128'(PCT_FULL);
        rhs = 128'(lim - hdr_r) * 128'(pct_r);
        if (lhs > rhs) begin
            if (!place_fresh()) return ST_FULL;
            kind_r = KIND_COMPACT;
            kept_r = 0;
            return ST_OK;
        end
        reg_end = lim;
        kind_r = KIND_OVER;
        kept_r = nk;
        return ST_OK;
    endfunction

    task automatic predict_layout(input t_layout_item it);
        t_layout_answer ans;
        logic [1:0]     code;
        bit             sticky;
        ans = '{default: '0};
        case (it.op)
            OP_LOAD_PREV: begin
                if (prev_n < NPREV) begin
                    pv_idh[prev_n] = it.idh;
                    pv_idl[prev_n] = it.idl;
                    pv_arch[prev_n] = it.arch;
                    pv_size[prev_n] = it.size;
                    pv_off[prev_n] = it.off;
                    prev_n++;
                end else begin
                    stat_r = ST_FULL;
                end
            end
            OP_LOAD_SLICE: begin
                if (slice_n < NSLICE) begin
                    sl_idh[slice_n] = it.idh;
                    sl_idl[slice_n] = it.idl;
                    sl_arch[slice_n] = it.arch;
                    sl_size[slice_n] = it.size;
                    sl_off[slice_n] = 0;
                    sl_kept[slice_n] = 0;
                    slice_n++;
                end else begin
                    stat_r = ST_FULL;
                end
            end
            default: begin
                if (it.op == OP_RUN) begin
                    sticky = (stat_r == ST_FULL);
                    code = place_slices();
                    if (code != ST_OK) begin
                        for (int i = 0; i < slice_n; i++) begin
                            sl_off[i] = 0;
                            sl_kept[i] = 0;
                        end
                        reg_end = 0;
                        kind_r = KIND_FRESH;
                        kept_r = 0;
                        stat_r = code;
                    end else begin
                        stat_r = ST_OK;
                    end
                    if (sticky) stat_r = ST_FULL;
                end else if (int'(it.q) < slice_n) begin
                    ans.offset = sl_off[it.q][OBITS-1:0];
                    ans.kept = sl_kept[it.q];
                end
                ans.kind = kind_r;
                ans.kept_total = KEPT_W'(kept_r);
                ans.region_end = reg_end[OBITS-1:0];
                ans.status = stat_r;
                expected_answers = {expected_answers, ans};
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("MISMATCH cycle %0d %s: got %0h expected %0h", cycle_count, what, got, want);
    endtask

    // monitor: check results, predict accepted items, track config writes
    always @(posedge clk) begin : monitor_proc
        t_layout_answer want;
        t_layout_item   it;
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected result", 64'(placed_offset), 0);
                end else begin
                    want = expected_answers.pop_front();
                    if (placed_offset !== want.offset)
                        report_mismatch("placed_offset", 64'(placed_offset), 64'(want.offset));
                    if (was_kept !== want.kept)
                        report_mismatch("was_kept", 64'(was_kept), 64'(want.kept));
                    if (layout_kind !== want.kind)
                        report_mismatch("layout_kind", 64'(layout_kind), 64'(want.kind));
                    if (kept_total !== want.kept_total)
                        report_mismatch("kept_total", 64'(kept_total), 64'(want.kept_total));
                    if (region_end !== want.region_end)
                        report_mismatch("region_end", 64'(region_end), 64'(want.region_end));
                    if (status !== want.status)
                        report_mismatch("status", 64'(status), 64'(want.status));
                end
            end
            if (in_valid && in_ready) begin
                it.op = operation;
                it.idh = id_high;
                it.idl = id_low;
                it.arch = archive_number;
                it.size = stored_bytes;
                it.off = old_offset;
                it.q = query_index;
                predict_layout(it);
                in_took = 1;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_HEADER) hdr_r = 64'(cfg_data);
                else pct_r = 64'(cfg_data[PCT_W-1:0]);
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk) begin
        if (hold_start != hold_seen) begin
            hold_seen <= hold_start;
            hold_left <= HOLD_LEN;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver stall pattern
    always @(negedge clk) begin : receiver_proc
        int rx_mode;
        int rx_timer;
        if (rx_timer <= 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_timer = $urandom_range(50, 300);
        end
        rx_timer--;
        if (hold_left > 0) out_ready <= 0;
        else if (rx_mode == 0) out_ready <= 1;
        else if (rx_mode == 1) out_ready <= $urandom_range(0, 1);
        else out_ready <= ($urandom_range(0, 9) == 0);
    end

    // driver: bursts of items with random gaps
    always @(negedge clk) begin : driver_proc
        t_layout_item it;
        int burst_left;
        int gap_left;
        if (rst_n && (!in_valid || in_took)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 0;
            end else if (item_backlog.size() > 0) begin
                it = item_backlog.pop_front();
                operation <= it.op;
                id_high <= it.idh;
                id_low <= it.idl;
                archive_number <= it.arch;
                stored_bytes <= it.size;
                old_offset <= it.off;
                query_index <= it.q;
                in_valid <= 1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                in_valid <= 0;
            end
        end
        in_took = 0;
    end

    function automatic t_layout_item rand_item(input logic [1:0] op);
        t_layout_item it;
        it.op = op;
        it.idh = {$urandom, $urandom};
        it.idl = {$urandom, $urandom};
        it.arch = 16'($urandom);
        it.size = OBITS'({$urandom, $urandom});
        it.off = OBITS'({$urandom, $urandom});
        it.q = 8'($urandom);
        return it;
    endfunction

    task automatic add_item(input logic [1:0] op, input logic [63:0] idh, input logic [63:0] idl,
                            input logic [15:0] arch, input logic [39:0] size,
                            input logic [39:0] off, input logic [7:0] q);
        t_layout_item it;
        it = rand_item(op);
        if (op == OP_LOAD_PREV || op == OP_LOAD_SLICE) begin
            it.idh = idh;
            it.idl = idl;
            it.arch = arch;
            it.size = size;
        end
        if (op == OP_LOAD_PREV) it.off = off;
        if (op == OP_QUERY) it.q = q;
        if (op == OP_LOAD_PREV) gen_prevs++;
        if (op == OP_LOAD_SLICE) gen_slices++;
        item_backlog = {item_backlog, it};
    endtask

    task automatic add_query();
        int hi;
        hi = (gen_slices + 4 > 255) ? 255 : gen_slices + 4;
        if ($urandom_range(0, 7) == 0) add_item(OP_QUERY, 0, 0, 0, 0, 0, 8'($urandom));
        else add_item(OP_QUERY, 0, 0, 0, 0, 0, 8'($urandom_range(0, hi)));
    endtask

    task automatic gen_prev_entry();
        logic [63:0] idh, idl;
        logic [15:0] arch;
        logic [39:0] size, off;
        int          j;
        bit          dup;
        dup = (gp_idh.size() > 0) && ($urandom_range(0, 7) == 0);
        if (dup) begin
            j = $urandom_range(0, gp_idh.size() - 1);
            idh = gp_idh[j];
            idl = gp_idl[j];
        end else begin
            idh = {$urandom, $urandom};
            idl = {$urandom, $urandom};
        end
        case ($urandom_range(0, 3))
            0: arch = 16'h0000;
            1: arch = 16'hFFFF;
            default: arch = 16'($urandom);
        endcase
        size = ($urandom_range(0, 15) == 0) ? 40'd0 : 40'($urandom_range(1, 3000));
        off = gen_cursor;
        if ($urandom_range(0, 2) == 0) off = off + 40'($urandom_range(1, 500));
        gen_cursor = off + size;
        gp_idh = {gp_idh, idh};
        gp_idl = {gp_idl, idl};
        gp_arch = {gp_arch, arch};
        gp_size = {gp_size, size};
        // a later duplicate never wins, so never aim a slice at it
        gp_used = {gp_used, dup};
        add_item(OP_LOAD_PREV, idh, idl, arch, size, off, 0);
    endtask

    task automatic gen_slice();
        int          cand[$];
        int          j;
        logic [15:0] arch;
        logic [39:0] size;
        for (int i = 0; i < gp_used.size(); i++)
            if (!gp_used[i]) cand = {cand, i};
        if (cand.size() > 0 && $urandom_range(0, 9) < 6) begin
            j = cand[$urandom_range(0, cand.size() - 1)];
            gp_used[j] = 1;
            arch = gp_arch[j];
            size = 40'($urandom_range(0, int'(gp_size[j])));
            case ($urandom_range(0, 9))
                0: arch = arch ^ 16'($urandom_range(1, 65535));
                1: size = gp_size[j] + 40'($urandom_range(1, 100));
                2: size = gp_size[j];
                default: ;
            endcase
            add_item(OP_LOAD_SLICE, gp_idh[j], gp_idl[j], arch, size, 0, 0);
        end else begin
            add_item(OP_LOAD_SLICE, {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                     40'($urandom_range(0, 3000)), 0, 0);
        end
    endtask

    task automatic wait_idle();
        while (item_backlog.size() != 0 || in_valid || expected_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    initial begin
        logic [15:0] hdr_pick;
        logic [15:0] pct_pick;
        t_layout_item it;
        rst_n = 0;
        in_valid = 0;
        operation = OP_QUERY;
        id_high = 0;
        id_low = 0;
        archive_number = 0;
        stored_bytes = 0;
        old_offset = 0;
        query_index = 0;
        out_ready = 0;
        cfg_valid = 0;
        cfg_index = CFG_HEADER;
        cfg_data = 0;
        hdr_r = 64'(HEADER_RST);
        pct_r = 64'(PCT_RST);
        reg_end = 0;
        prev_n = 0;
        slice_n = 0;
        kind_r = KIND_FRESH;
        kept_r = 0;
        stat_r = ST_OK;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // fresh layouts with no previous entries
        add_item(OP_QUERY, 0, 0, 0, 0, 0, 8'd0);
        add_item(OP_QUERY, 0, 0, 0, 0, 0, 8'd255);
        add_item(OP_RUN, 0, 0, 0, 0, 0, 0);
        add_item(OP_LOAD_SLICE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF,
                 40'd0, 0, 0);
        add_item(OP_LOAD_SLICE, 64'd0, 64'd0, 16'h0000, 40'd1, 0, 0);
        add_item(OP_LOAD_SLICE, 64'd1, 64'd2, 16'h1234, 40'd777, 0, 0);
        add_item(OP_QUERY, 0, 0, 0, 0, 0, 8'd2);
        add_item(OP_RUN, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 4; i++) add_item(OP_QUERY, 0, 0, 0, 0, 0, 8'(i));
        wait_idle();
        write_cfg(CFG_HEADER, 16'd0);
        write_cfg(CFG_PCT, 16'd0);
        add_item(OP_RUN, 0, 0, 0, 0, 0, 0);
        add_item(OP_QUERY, 0, 0, 0, 0, 0, 8'd0);
        add_item(OP_QUERY, 0, 0, 0, 0, 0, 8'd2);
        wait_idle();
        write_cfg(CFG_HEADER, 16'hFFFF);
        write_cfg(CFG_PCT, 16'h007F);
        add_item(OP_RUN, 0, 0, 0, 0, 0, 0);
        add_item(OP_QUERY, 0, 0, 0, 0, 0, 8'd1);
        add_item(OP_QUERY, 0, 0, 0, 0, 0, 8'd3);
        wait_idle();
        write_cfg(CFG_HEADER, 16'd64);
        write_cfg(CFG_PCT, 16'd25);

        // layouts over previous entries
        for (int r = 0; r < ROUNDS; r++) begin
            if (r == 3) hold_start++;
            repeat (3) gen_prev_entry();
            repeat (4) gen_slice();
            repeat (2) begin
                it = rand_item(($urandom_range(0, 1) == 0) ? OP_LOAD_PREV : OP_QUERY);
                if (it.op == OP_LOAD_PREV) gen_prevs++;
                item_backlog = {item_backlog, it};
            end
            if ($urandom_range(0, 2) == 0) repeat (3) add_query();
            add_item(OP_RUN, 0, 0, 0, 0, 0, 0);
            if ($urandom_range(0, 5) == 0) add_item(OP_RUN, 0, 0, 0, 0, 0, 0);
            repeat (22) add_query();
            if (r % 5 == 4) begin
                wait_idle();
                case ($urandom_range(0, 3))
                    0: hdr_pick = 16'd0;
                    1: hdr_pick = 16'd64;
                    2: hdr_pick = 16'd2000;
                    default: hdr_pick = 16'($urandom_range(0, 2000));
                endcase
                case ((r / 5) % 5)
                    0: pct_pick = 16'd0;
                    1: pct_pick = 16'd100;
                    2: pct_pick = 16'd127;
                    3: pct_pick = 16'd25;
                    default: pct_pick = 16'($urandom_range(0, 127));
                endcase
                write_cfg(CFG_HEADER, hdr_pick);
                write_cfg(CFG_PCT, pct_pick);
            end
            if (r == 12) begin
                // header past every kept slice
                wait_idle();
                write_cfg(CFG_HEADER, 16'hFFFF);
                add_item(OP_RUN, 0, 0, 0, 0, 0, 0);
                repeat (4) add_query();
                wait_idle();
                write_cfg(CFG_HEADER, 16'd64);
            end
        end

        // overlapping kept slices
        wait_idle();
        write_cfg(CFG_HEADER, 16'd64);
        add_item(OP_LOAD_PREV, 64'hA5, 64'h1, 16'd7, 40'd50, 40'd100, 0);
        add_item(OP_LOAD_PREV, 64'hA5, 64'h2, 16'd7, 40'd50, 40'd120, 0);
        add_item(OP_LOAD_SLICE, 64'hA5, 64'h1, 16'd7, 40'd50, 0, 0);
        add_item(OP_LOAD_SLICE, 64'hA5, 64'h2, 16'd7, 40'd50, 0, 0);
        add_item(OP_RUN, 0, 0, 0, 0, 0, 0);
        repeat (6) add_query();

        // kept slice ending past the offset range
        add_item(OP_LOAD_PREV, 64'h5A, 64'h3, 16'hFFFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FF00, 0);
        add_item(OP_LOAD_SLICE, 64'h5A, 64'h3, 16'hFFFF, 40'h80_0000_0000, 0, 0);
        add_item(OP_RUN, 0, 0, 0, 0, 0, 0);
        repeat (6) add_query();

        // fill both tables past capacity
        while (gen_slices < NSLICE + 3) begin
            add_item(OP_LOAD_SLICE, {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                     40'($urandom_range(0, 3000)), 0, 0);
            if ($urandom_range(0, 3) == 0) add_query();
        end
        add_item(OP_QUERY, 0, 0, 0, 0, 0, 8'd255);
        repeat (10) add_query();
        while (gen_prevs < NPREV + 3) begin
            it = rand_item(OP_LOAD_PREV);
            gen_prevs++;
            item_backlog = {item_backlog, it};
            if ($urandom_range(0, 3) == 0) add_query();
        end
        repeat (10) add_query();

        wait_idle();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && expected_answers.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
